// ===== rtl/rrp_pkg.sv =====
// Shared types and constants for the request parser.
// Holds parse modes, event codes, the result struct and the ping line table.
// No dependencies.
package rrp_pkg;

  typedef enum logic [3:0] {
    MODE_START,
    MODE_PING,
    MODE_COUNT,
    MODE_ELEM,
    MODE_TEXT,
    MODE_BULKLEN,
    MODE_PAYLOAD,
    MODE_TRAIL1,
    MODE_TRAIL2,
    MODE_DROP
  } mode_t;

  typedef enum logic [2:0] {
    EV_BYTE   = 3'd0,
    EV_ARGEND = 3'd1,
    EV_CMDEND = 3'd2,
    EV_PONG   = 3'd3,
    EV_ERROR  = 3'd4
  } event_t;

  localparam int ARGS_W = 21;
  localparam int BULK_W = 30;
  localparam int IDX_W  = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 30;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_ARGS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BULK = 2'd1;

  localparam logic [ARGS_W-1:0] MAX_ARGS_RST = 21'd1024;
  localparam logic [BULK_W-1:0] MAX_BULK_RST = 30'd536870912;

  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [2:0] PING_LAST_POS = 3'd5;

  typedef struct packed {
    logic             valid;
    event_t           ev;
    logic [7:0]       data;
    logic [IDX_W-1:0] idx;
    logic             last;
  } result_t;

  function automatic logic [7:0] ping_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h50;
      3'd1:    c = 8'h49;
      3'd2:    c = 8'h4e;
      3'd3:    c = 8'h47;
      3'd4:    c = 8'd13;
      3'd5:    c = 8'd10;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/resp_request_parser_top.sv =====
// Request parser top level: configuration registers, input and result registers.
// Accepted bytes wait in the input register; parser results are held in the output register.
// Throughput: one byte per cycle while out_stall does not hold the output register.
// Reset: synchronous active-low rst_n clears the parse state, both valid flags,
// and loads the default argument and bulk length limits. Depends on rrp_pkg, rrp_parser.
module resp_request_parser_top #(
  parameter int NUMBER_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_byte_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      out_event_res,
  output logic [7:0]                      out_data_byte,
  output logic [rrp_pkg::IDX_W-1:0]       out_arg_index,
  output logic                            out_last_of_command,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rrp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rrp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [rrp_pkg::ARGS_W-1:0] max_args_r;
  logic [rrp_pkg::BULK_W-1:0] max_bulk_r;
  logic [7:0]                 byte_r;
  logic                       in_valid_r;
  logic                       out_valid_r;
  rrp_pkg::result_t           out_r;
  rrp_pkg::result_t           res;
  logic                       advance;
  logic                       step_en;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = in_valid_r && !advance;
  assign step_en   = in_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_args_r <= rrp_pkg::MAX_ARGS_RST;
      max_bulk_r <= rrp_pkg::MAX_BULK_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rrp_pkg::REG_MAX_ARGS: max_args_r <= cfg_data[rrp_pkg::ARGS_W-1:0];
        rrp_pkg::REG_MAX_BULK: max_bulk_r <= cfg_data[rrp_pkg::BULK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= in_byte_in;
    end
  end

  rrp_parser #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .step_en         (step_en),
    .byte_in         (byte_r),
    .max_arguments   (max_args_r),
    .max_bulk_length (max_bulk_r),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= step_en && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && res.valid) begin
      out_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_event_res       = out_r.ev;
  assign out_data_byte       = out_r.data;
  assign out_arg_index       = out_r.idx;
  assign out_last_of_command = out_r.last;

endmodule

// ===== rtl/rrp_parser.sv =====
// Parser state and one-byte step logic for the request parser.
// Updates the parse state for each stepped byte and forms at most one result.
// Depends on rrp_pkg.
module rrp_parser #(
  parameter int NUMBER_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step_en,
  input  logic [7:0]                   byte_in,
  input  logic [rrp_pkg::ARGS_W-1:0]   max_arguments,
  input  logic [rrp_pkg::BULK_W-1:0]   max_bulk_length,
  output rrp_pkg::result_t             res
);

  localparam int NW = NUMBER_WIDTH;
  localparam int PW = NW + 4;
  localparam int CW = (NW > 32) ? NW : 32;

  rrp_pkg::mode_t mode_r, mode_nxt;
  logic [NW-1:0]              acc_r, acc_nxt;
  logic                       has_digit_r, has_digit_nxt;
  logic [rrp_pkg::ARGS_W-1:0] args_r, args_nxt;
  logic [rrp_pkg::BULK_W-1:0] bulk_r, bulk_nxt;
  logic [rrp_pkg::IDX_W-1:0]  cur_r, cur_nxt;
  logic [2:0]                 pos_r, pos_nxt;
  logic                       prev_cr_r, prev_cr_nxt;

  logic          is_digit;
  logic [3:0]    digit;
  logic [PW-1:0] prod;
  logic [NW-1:0] acc_step;
  logic [CW-1:0] acc_ext;
  logic [CW-1:0] limit_ext;
  logic          num_bad;
  logic          last_arg;

  logic do_fail, fail_eol, do_close, num_ok, emit_byte, emit_pong;

  assign is_digit  = (byte_in >= rrp_pkg::CH_ZERO) && (byte_in <= rrp_pkg::CH_NINE);
  assign digit     = 4'(byte_in - rrp_pkg::CH_ZERO);
  assign prod      = (PW'(acc_r) << 3) + (PW'(acc_r) << 1) + PW'(digit);
  assign acc_step  = (prod[PW-1:NW] != 4'd0) ? {NW{1'b1}} : prod[NW-1:0];
  assign acc_ext   = CW'(acc_r);
  assign limit_ext = (mode_r == rrp_pkg::MODE_COUNT) ? CW'(max_arguments)
                                                     : CW'(max_bulk_length);
  assign num_bad   = !has_digit_r || (acc_r == '0) || (acc_ext > limit_ext);
  assign last_arg  = (args_r <= rrp_pkg::ARGS_W'(1));

  // Step decode shared by the next-state and output logic.
  always_comb begin
    do_fail   = 1'b0;
    fail_eol  = 1'b0;
    do_close  = 1'b0;
    num_ok    = 1'b0;
    emit_byte = 1'b0;
    emit_pong = 1'b0;
    unique case (mode_r)
      rrp_pkg::MODE_PING: begin
        if ((pos_r > rrp_pkg::PING_LAST_POS) || (byte_in != rrp_pkg::ping_char(pos_r))) begin
          do_fail = 1'b1;
        end else if (pos_r == rrp_pkg::PING_LAST_POS) begin
          emit_pong = 1'b1;
        end
      end
      rrp_pkg::MODE_COUNT, rrp_pkg::MODE_BULKLEN: begin
        if (prev_cr_r) begin
          if (byte_in != rrp_pkg::CH_LF) begin
            do_fail = 1'b1;
          end else if (num_bad) begin
            do_fail  = 1'b1;
            fail_eol = 1'b1;
          end else begin
            num_ok = 1'b1;
          end
        end else if ((byte_in != rrp_pkg::CH_CR) && !is_digit) begin
          do_fail = 1'b1;
        end
      end
      rrp_pkg::MODE_ELEM: begin
        if ((byte_in != rrp_pkg::CH_PLUS) && (byte_in != rrp_pkg::CH_COLON) &&
            (byte_in != rrp_pkg::CH_DOLLAR)) begin
          do_fail = 1'b1;
        end
      end
      rrp_pkg::MODE_TEXT: begin
        if (prev_cr_r) begin
          if (byte_in == rrp_pkg::CH_LF) begin
            do_close = 1'b1;
          end else begin
            do_fail = 1'b1;
          end
        end else if (byte_in != rrp_pkg::CH_CR) begin
          emit_byte = 1'b1;
        end
      end
      rrp_pkg::MODE_PAYLOAD: begin
        emit_byte = 1'b1;
      end
      rrp_pkg::MODE_TRAIL2: begin
        do_close = 1'b1;
      end
      rrp_pkg::MODE_TRAIL1, rrp_pkg::MODE_DROP: begin
      end
      default: begin
        if ((byte_in != rrp_pkg::CH_STAR) && (byte_in != rrp_pkg::CH_P)) begin
          do_fail = 1'b1;
        end
      end
    endcase
  end

  // Next state.
  always_comb begin
    mode_nxt      = mode_r;
    acc_nxt       = acc_r;
    has_digit_nxt = has_digit_r;
    args_nxt      = args_r;
    bulk_nxt      = bulk_r;
    cur_nxt       = cur_r;
    pos_nxt       = pos_r;
    prev_cr_nxt   = prev_cr_r;
    unique case (mode_r)
      rrp_pkg::MODE_PING: begin
        if (pos_r == rrp_pkg::PING_LAST_POS) begin
          pos_nxt  = 3'd0;
          mode_nxt = rrp_pkg::MODE_START;
        end else begin
          pos_nxt = pos_r + 3'd1;
        end
      end
      rrp_pkg::MODE_COUNT, rrp_pkg::MODE_BULKLEN: begin
        if (num_ok) begin
          prev_cr_nxt = 1'b0;
          if (mode_r == rrp_pkg::MODE_COUNT) begin
            args_nxt = acc_ext[rrp_pkg::ARGS_W-1:0];
            cur_nxt  = '0;
            mode_nxt = rrp_pkg::MODE_ELEM;
          end else begin
            bulk_nxt = acc_ext[rrp_pkg::BULK_W-1:0];
            mode_nxt = rrp_pkg::MODE_PAYLOAD;
          end
        end else if (byte_in == rrp_pkg::CH_CR) begin
          prev_cr_nxt = 1'b1;
        end else begin
          acc_nxt       = acc_step;
          has_digit_nxt = 1'b1;
        end
      end
      rrp_pkg::MODE_ELEM: begin
        if (byte_in == rrp_pkg::CH_DOLLAR) begin
          acc_nxt       = '0;
          has_digit_nxt = 1'b0;
          prev_cr_nxt   = 1'b0;
          mode_nxt      = rrp_pkg::MODE_BULKLEN;
        end else begin
          prev_cr_nxt = 1'b0;
          mode_nxt    = rrp_pkg::MODE_TEXT;
        end
      end
      rrp_pkg::MODE_TEXT: begin
        if (!prev_cr_r && (byte_in == rrp_pkg::CH_CR)) begin
          prev_cr_nxt = 1'b1;
        end
      end
      rrp_pkg::MODE_PAYLOAD: begin
        if (bulk_r <= rrp_pkg::BULK_W'(1)) begin
          bulk_nxt = '0;
          mode_nxt = rrp_pkg::MODE_TRAIL1;
        end else begin
          bulk_nxt = bulk_r - rrp_pkg::BULK_W'(1);
        end
      end
      rrp_pkg::MODE_TRAIL1: begin
        mode_nxt = rrp_pkg::MODE_TRAIL2;
      end
      rrp_pkg::MODE_TRAIL2: begin
      end
      rrp_pkg::MODE_DROP: begin
        if (prev_cr_r && (byte_in == rrp_pkg::CH_LF)) begin
          prev_cr_nxt = 1'b0;
          mode_nxt    = rrp_pkg::MODE_START;
        end else begin
          prev_cr_nxt = (byte_in == rrp_pkg::CH_CR);
        end
      end
      default: begin
        args_nxt = '0;
        cur_nxt  = '0;
        if (byte_in == rrp_pkg::CH_STAR) begin
          acc_nxt       = '0;
          has_digit_nxt = 1'b0;
          prev_cr_nxt   = 1'b0;
          mode_nxt      = rrp_pkg::MODE_COUNT;
        end else begin
          pos_nxt  = 3'd1;
          mode_nxt = rrp_pkg::MODE_PING;
        end
      end
    endcase

    if (do_close) begin
      prev_cr_nxt = 1'b0;
      if (last_arg) begin
        args_nxt = '0;
        cur_nxt  = '0;
        mode_nxt = rrp_pkg::MODE_START;
      end else begin
        args_nxt = args_r - rrp_pkg::ARGS_W'(1);
        cur_nxt  = cur_r + rrp_pkg::IDX_W'(1);
        mode_nxt = rrp_pkg::MODE_ELEM;
      end
    end

    if (do_fail) begin
      args_nxt      = '0;
      bulk_nxt      = '0;
      cur_nxt       = '0;
      pos_nxt       = 3'd0;
      acc_nxt       = '0;
      has_digit_nxt = 1'b0;
      prev_cr_nxt   = !fail_eol && (byte_in == rrp_pkg::CH_CR);
      mode_nxt      = fail_eol ? rrp_pkg::MODE_START : rrp_pkg::MODE_DROP;
    end
  end

  // Result of the step.
  always_comb begin
    res.valid = do_fail || do_close || emit_byte || emit_pong;
    res.data  = emit_byte ? byte_in : 8'd0;
    res.idx   = (emit_byte || do_close) ? cur_r : '0;
    res.last  = do_close && last_arg;
    if (do_fail) begin
      res.ev = rrp_pkg::EV_ERROR;
    end else if (do_close) begin
      res.ev = last_arg ? rrp_pkg::EV_CMDEND : rrp_pkg::EV_ARGEND;
    end else if (emit_pong) begin
      res.ev = rrp_pkg::EV_PONG;
    end else begin
      res.ev = rrp_pkg::EV_BYTE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= rrp_pkg::MODE_START;
      acc_r       <= '0;
      has_digit_r <= 1'b0;
      args_r      <= '0;
      bulk_r      <= '0;
      cur_r       <= '0;
      pos_r       <= 3'd0;
      prev_cr_r   <= 1'b0;
    end else if (step_en) begin
      mode_r      <= mode_nxt;
      acc_r       <= acc_nxt;
      has_digit_r <= has_digit_nxt;
      args_r      <= args_nxt;
      bulk_r      <= bulk_nxt;
      cur_r       <= cur_nxt;
      pos_r       <= pos_nxt;
      prev_cr_r   <= prev_cr_nxt;
    end
  end

endmodule
